### rtl/core/arpc_pkg.sv
// Shared types and constants for the ARP cache table.
package arpc_pkg;

  // Field widths of a request and of a result.
  localparam int unsigned REQ_W = 2;
  localparam int unsigned IP_W  = 32;
  localparam int unsigned MAC_W = 48;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // One table entry as it travels along the ring of cells.
  typedef struct packed {
    logic             valid;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } entry_t;

endpackage

### rtl/core/arpc_if.sv
// Request and response channel interfaces of the ARP cache table.
interface arpc_req_if;
  logic                        valid;
  logic                        ready;
  logic [arpc_pkg::REQ_W-1:0]  req_type;
  logic [arpc_pkg::IP_W-1:0]   ip_address;
  logic [arpc_pkg::MAC_W-1:0]  new_mac;

  modport source (output valid, req_type, ip_address, new_mac, input ready);
  modport sink   (input valid, req_type, ip_address, new_mac, output ready);
endinterface

interface arpc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [arpc_pkg::MAC_W-1:0]  found_mac;

  modport source (output valid, status, found_mac, input ready);
  modport sink   (input valid, status, found_mac, output ready);
endinterface

### rtl/core/arpc_cell.sv
// One storage cell of the rotating entry ring.
module arpc_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic             clear_i,
  input  arpc_pkg::entry_t entry_i,
  output arpc_pkg::entry_t entry_o
);

  logic                        valid_q;
  logic [arpc_pkg::IP_W-1:0]   ip_q;
  logic [arpc_pkg::MAC_W-1:0]  mac_q;

  // The valid bit drops on reset or on a clear; otherwise it moves with the ring.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  // Address and MAC take the neighbor's contents on every shift.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ip_q  <= entry_i.ip;
      mac_q <= entry_i.mac;
    end
  end

  assign entry_o = '{valid: valid_q, ip: ip_q, mac: mac_q};

endmodule

### rtl/core/arp_cache_table_top.sv
// ARP cache table: ENTRIES cells form a ring that rotates past one compare unit at the head.
// Add and lookup stage their result after one full rotation of the ring through the SCAN state;
// clear and unused codes go straight to the DONE state, which stages the result.
// One request is in progress at a time; the next is taken once the result is staged,
// and a result that is not taken keeps the sequencer waiting in the DONE state.
// Reset is asynchronous and active low; it clears every valid bit, the control and the output valid.
module arp_cache_table_top #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  arpc_req_if.sink       req_i,
  arpc_rsp_if.source     rsp_o
);

  localparam int unsigned CntW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(ENTRIES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [arpc_pkg::REQ_W-1:0]  op_q, op_d;
  logic [arpc_pkg::IP_W-1:0]   ip_q, ip_d;
  logic [arpc_pkg::MAC_W-1:0]  new_mac_q, new_mac_d;
  logic                        hit_q, hit_d;
  logic [arpc_pkg::MAC_W-1:0]  res_mac_q, res_mac_d;
  logic                        rsp_valid_q, rsp_valid_d;
  logic                        rsp_status_q, rsp_status_d;
  logic [arpc_pkg::MAC_W-1:0]  rsp_mac_q, rsp_mac_d;

  logic             req_fire;
  logic             shift;
  logic             clear_cells;
  logic             take_slot;
  logic             match;
  arpc_pkg::entry_t head;
  arpc_pkg::entry_t ring_in;
  arpc_pkg::entry_t cell_out [ENTRIES];
  logic [ENTRIES-1:0] valid_vec;

  // Ring of cells: each takes its upper neighbor; the last takes the head or the added entry.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    arpc_pkg::entry_t cell_in;
    if (i == ENTRIES - 1) begin : g_tail
      assign cell_in = ring_in;
    end else begin : g_mid
      assign cell_in = cell_out[i+1];
    end
    arpc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .clear_i (clear_cells),
      .entry_i (cell_in),
      .entry_o (cell_out[i])
    );
    assign valid_vec[i] = cell_out[i].valid;
  end

  // Head of the ring: during step k it holds entry k, so the first hit is the lowest index.
  assign head      = cell_out[0];
  assign shift     = (state_q == ST_SCAN);
  assign take_slot = shift && (op_q == arpc_pkg::REQ_ADD) && !hit_q && !head.valid;
  assign match     = shift && (op_q == arpc_pkg::REQ_LOOKUP) && !hit_q && head.valid &&
                     (head.ip == ip_q);
  assign ring_in   = take_slot ? '{valid: 1'b1, ip: ip_q, mac: new_mac_q} : head;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // Sequencer: accept, rotate the ring once for add and lookup, then stage the result in the output register.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    op_d         = op_q;
    ip_d         = ip_q;
    new_mac_d    = new_mac_q;
    hit_d        = hit_q;
    res_mac_d    = res_mac_q;
    clear_cells  = 1'b0;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_mac_d    = rsp_mac_q;

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          op_d      = req_i.req_type;
          ip_d      = req_i.ip_address;
          new_mac_d = req_i.new_mac;
          res_mac_d = '0;
          cnt_d     = '0;
          case (req_i.req_type)
            arpc_pkg::REQ_ADD, arpc_pkg::REQ_LOOKUP: begin
              hit_d   = 1'b0;
              state_d = ST_SCAN;
            end
            arpc_pkg::REQ_CLEAR: begin
              clear_cells = 1'b1;
              hit_d       = 1'b1;
              state_d     = ST_DONE;
            end
            default: begin
              hit_d   = 1'b0;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (take_slot || match) begin
          hit_d = 1'b1;
        end
        if (match) begin
          res_mac_d = head.mac;
        end
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntLast) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = hit_q ? arpc_pkg::STATUS_OK : arpc_pkg::STATUS_FAIL;
          rsp_mac_d    = res_mac_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers of the request in progress and of the staged result.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    ip_q         <= ip_d;
    new_mac_q    <= new_mac_d;
    res_mac_q    <= res_mac_d;
    rsp_status_q <= rsp_status_d;
    rsp_mac_q    <= rsp_mac_d;
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = rsp_status_q;
  assign rsp_o.found_mac = rsp_mac_q;

`ifndef NO_ASSERTIONS
  // A scan ends after exactly one rotation of the ring.
  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cnt_q == CntLast) |=> (state_q == ST_DONE))
    else $error("scan did not end after one rotation");

  // A staged result that is not taken keeps the sequencer waiting.
  a_hold_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && rsp_valid_q && !rsp_o.ready) |=> (state_q == ST_DONE))
    else $error("result overwritten before it was taken");

  // A failed request never reports a MAC.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == arpc_pkg::STATUS_FAIL) |-> (rsp_o.found_mac == '0))
    else $error("failure reported with a nonzero MAC");

  // A clear transaction empties the whole table.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.req_type == arpc_pkg::REQ_CLEAR) |=> (valid_vec == '0))
    else $error("valid bits left after clear");
`endif

endmodule
